[src/bounded_array_list_engine_unit_assert.svh]
// ============================================================================
// Assertion macros for the bounded array list engine
// Shared concurrent assertion forms, clocked and disabled during reset.
// ============================================================================
`ifndef BOUNDED_ARRAY_LIST_ENGINE_UNIT_ASSERT_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BAL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bal assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bal assertion failed");

`endif

[src/bal_pkg.sv]
// ============================================================================
// bal_pkg
// Constants, codes and shared types of the bounded array list engine.
// ============================================================================
package bal_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // Fixed widths of the result fields.
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 4;
    localparam int RCNT_W  = 5;
    localparam int LEN_W   = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_SEARCH     = 3'd4,
        REQ_REMOVE_ALL = 3'd5
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    // Movement command broadcast to every cell of the chain.
    typedef struct packed {
        logic shift_up;
        logic shift_down;
    } cell_ctl_t;

endpackage

[src/bounded_array_list_engine_unit.sv]
// ============================================================================
// bounded_array_list_engine_unit
// Bounded ordered list of 32-bit words with deque, search and remove-all.
// ============================================================================
// The list lives in a chain of DEPTH cells, entry 0 at the front. Insert at
// back or front and remove from front or back need no scan: the
// transaction is accepted, and its result is presented on the next cycle,
// so these requests run back to back while the result side keeps up.
// Search and remove-all rotate the list once through cell 0, one entry per
// cycle, comparing the front word and writing kept words behind the unscanned
// part; such a transaction occupies the block until every entry present
// when it was accepted has been scanned (no scan when the list is empty).
// The request side is stalled while a rotation runs or an unread result
// would otherwise be overwritten.
`include "bounded_array_list_engine_unit_assert.svh"

module bounded_array_list_engine_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [bal_pkg::REQ_W-1:0]          req_type,
    input  logic signed [bal_pkg::DATA_W-1:0]  value,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [bal_pkg::STAT_W-1:0]         status,
    output logic signed [bal_pkg::DATA_W-1:0]  data,
    output logic [bal_pkg::POS_W-1:0]          position,
    output logic [bal_pkg::RCNT_W-1:0]         removed_count,
    output logic [bal_pkg::LEN_W-1:0]          length
);

    localparam int DEPTH  = bal_pkg::DEPTH;
    localparam int IDX_W  = bal_pkg::IDX_W;
    localparam int CNT_W  = bal_pkg::CNT_W;
    localparam int DATA_W = bal_pkg::DATA_W;

    bal_pkg::state_t            state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           rem_reg, rem_next;
    logic [CNT_W-1:0]           kept_reg, kept_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic                       found_reg, found_next;
    logic [IDX_W-1:0]           first_reg, first_next;
    logic                       remall_reg, remall_next;
    logic [DATA_W-1:0]          val_reg, val_next;

    logic                       rsp_valid_reg, rsp_valid_next;
    logic [bal_pkg::STAT_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0]          data_reg, data_next;
    logic [bal_pkg::POS_W-1:0]  position_reg, position_next;
    logic [bal_pkg::RCNT_W-1:0] removed_reg, removed_next;
    logic [bal_pkg::LEN_W-1:0]  length_reg, length_next;

    bal_pkg::cell_ctl_t         ctl;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_idx;
    logic [DATA_W-1:0]          wdata;
    logic [DATA_W-1:0]          cell_q [DEPTH];
    logic [DEPTH-1:0]           sel;

    logic                       accept;
    logic                       full;
    logic                       empty;
    logic [CNT_W-1:0]           count_dec;
    logic [CNT_W-1:0]           slot;
    logic                       hit;
    logic                       keep;
    logic                       any_hit;
    logic [IDX_W-1:0]           first_hit;

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_W-1:0] lower_w;
            logic [DATA_W-1:0] upper_w;

            if (gi == 0)
            begin : g_first
                assign lower_w = '0;
            end
            else
            begin : g_mid_lo
                assign lower_w = cell_q[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign upper_w = '0;
            end
            else
            begin : g_mid_hi
                assign upper_w = cell_q[gi+1];
            end

            assign sel[gi] = wr_en && (wr_idx == IDX_W'(gi));

            bal_cell u_cell (
                .clk   (clk),
                .ctl   (ctl),
                .sel   (sel[gi]),
                .wdata (wdata),
                .lower (lower_w),
                .upper (upper_w),
                .q     (cell_q[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    assign req_stall = !((state_reg == bal_pkg::S_IDLE) && (!rsp_valid_reg || !rsp_stall));
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign count_dec = count_reg - CNT_W'(1);

    // During a rotation the unscanned words sit in front of the kept ones;
    // after the shift the front word lands right behind the last kept word.
    assign slot      = rem_reg + kept_reg - CNT_W'(1);
    assign hit       = (cell_q[0] == val_reg);
    assign keep      = !remall_reg || !hit;
    assign any_hit   = found_reg || hit;
    assign first_hit = found_reg ? first_reg : idx_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        kept_next      = kept_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        first_next     = first_reg;
        remall_next    = remall_reg;
        val_next       = val_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        position_next  = position_reg;
        removed_next   = removed_reg;
        length_next    = length_reg;
        ctl            = '0;
        wr_en          = 1'b0;
        wr_idx         = '0;
        wdata          = value;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            bal_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = bal_pkg::ST_OK;
                    data_next      = '0;
                    position_next  = '0;
                    removed_next   = '0;
                    length_next    = bal_pkg::LEN_W'(count_reg);
                    case (req_type)
                        bal_pkg::REQ_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = bal_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                wr_idx        = count_reg[IDX_W-1:0];
                                count_next    = count_reg + CNT_W'(1);
                                position_next = bal_pkg::POS_W'(count_reg);
                                length_next   = bal_pkg::LEN_W'(count_reg + CNT_W'(1));
                            end
                        end
                        bal_pkg::REQ_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = bal_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctl.shift_up = 1'b1;
                                wr_en        = 1'b1;
                                wr_idx       = '0;
                                count_next   = count_reg + CNT_W'(1);
                                length_next  = bal_pkg::LEN_W'(count_reg + CNT_W'(1));
                            end
                        end
                        bal_pkg::REQ_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = bal_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ctl.shift_down = 1'b1;
                                data_next      = cell_q[0];
                                count_next     = count_dec;
                                length_next    = bal_pkg::LEN_W'(count_dec);
                            end
                        end
                        bal_pkg::REQ_POP_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = bal_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                data_next     = cell_q[count_dec[IDX_W-1:0]];
                                position_next = bal_pkg::POS_W'(count_dec);
                                count_next    = count_dec;
                                length_next   = bal_pkg::LEN_W'(count_dec);
                            end
                        end
                        bal_pkg::REQ_SEARCH, bal_pkg::REQ_REMOVE_ALL:
                        begin
                            if (empty)
                            begin
                                status_next = (req_type == bal_pkg::REQ_SEARCH)
                                              ? bal_pkg::ST_NOTFOUND : bal_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                rsp_valid_next = 1'b0;
                                state_next     = bal_pkg::S_SCAN;
                                rem_next       = count_reg;
                                kept_next      = '0;
                                idx_next       = '0;
                                found_next     = 1'b0;
                                first_next     = '0;
                                remall_next    = (req_type == bal_pkg::REQ_REMOVE_ALL);
                                val_next       = value;
                            end
                        end
                        default:
                        begin
                            status_next = bal_pkg::ST_OK;
                        end
                    endcase
                end
            end
            bal_pkg::S_SCAN:
            begin
                ctl.shift_down = 1'b1;
                wr_en          = keep;
                wr_idx         = slot[IDX_W-1:0];
                wdata          = cell_q[0];
                kept_next      = kept_reg + CNT_W'(keep);
                rem_next       = rem_reg - CNT_W'(1);
                idx_next       = idx_reg + IDX_W'(1);
                if (hit && !found_reg)
                begin
                    found_next = 1'b1;
                    first_next = idx_reg;
                end
                if (rem_reg == CNT_W'(1))
                begin
                    state_next     = bal_pkg::S_IDLE;
                    rsp_valid_next = 1'b1;
                    removed_next   = '0;
                    length_next    = bal_pkg::LEN_W'(count_reg);
                    if (any_hit)
                    begin
                        status_next   = bal_pkg::ST_OK;
                        data_next     = val_reg;
                        position_next = bal_pkg::POS_W'(first_hit);
                        if (remall_reg)
                        begin
                            count_next   = kept_next;
                            removed_next = bal_pkg::RCNT_W'(count_reg - kept_next);
                            length_next  = bal_pkg::LEN_W'(kept_next);
                        end
                    end
                    else
                    begin
                        status_next   = bal_pkg::ST_NOTFOUND;
                        data_next     = '0;
                        position_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = bal_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bal_pkg::S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rem_reg       <= '0;
            kept_reg      <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            rem_reg       <= rem_next;
            kept_reg      <= kept_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        first_reg    <= first_next;
        remall_reg   <= remall_next;
        val_reg      <= val_next;
        status_reg   <= status_next;
        data_reg     <= data_next;
        position_reg <= position_next;
        removed_reg  <= removed_next;
        length_reg   <= length_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign data          = data_reg;
    assign position      = position_reg;
    assign removed_count = removed_reg;
    assign length        = length_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BAL_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `BAL_ASSERT_SAME(a_scan_no_rsp, clk, rst_n, state_reg == bal_pkg::S_SCAN, !rsp_valid_reg)
    `BAL_ASSERT_SAME(a_scan_fill, clk, rst_n, state_reg == bal_pkg::S_SCAN,
        (rem_reg != '0) && ({1'b0, rem_reg} + {1'b0, kept_reg} <= {1'b0, count_reg}))
    `BAL_ASSERT_NEXT(a_full_holds, clk, rst_n,
        accept && full && (req_type == bal_pkg::REQ_PUSH_BACK || req_type == bal_pkg::REQ_PUSH_FRONT),
        $stable(count_reg) && status_reg == bal_pkg::ST_FULL)

endmodule

[src/bal_cell.sv]
// ============================================================================
// bal_cell
// One storage cell of the list chain: holds, loads, or takes a neighbor's word.
// ============================================================================
module bal_cell (
    input  logic                        clk,
    input  bal_pkg::cell_ctl_t          ctl,
    input  logic                        sel,
    input  logic [bal_pkg::DATA_W-1:0]  wdata,
    input  logic [bal_pkg::DATA_W-1:0]  lower,
    input  logic [bal_pkg::DATA_W-1:0]  upper,
    output logic [bal_pkg::DATA_W-1:0]  q
);

    logic [bal_pkg::DATA_W-1:0] data_reg;
    logic [bal_pkg::DATA_W-1:0] data_next;

    // A direct write wins over the shift so a slot can take a new word
    // while the rest of the chain moves.
    always_comb
    begin
        data_next = data_reg;
        if (sel)
        begin
            data_next = wdata;
        end
        else if (ctl.shift_up)
        begin
            data_next = lower;
        end
        else if (ctl.shift_down)
        begin
            data_next = upper;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

[tb/bounded_array_list_engine_unit_tb.sv]
// ============================================================================
// bounded_array_list_engine_unit_tb
// Self-checking testbench for the bounded array list engine. A directed
// table covers the empty and full lists, value extremes and every request
// code. Random deque, search and remove-all traffic follows, checked against
// a shadow list under changing sender and receiver idle rates.
// ============================================================================
module bounded_array_list_engine_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH  = bal_pkg::DEPTH;
    localparam int DATA_W = bal_pkg::DATA_W;
    localparam int REQ_W  = bal_pkg::REQ_W;
    localparam int STAT_W = bal_pkg::STAT_W;
    localparam int POS_W  = bal_pkg::POS_W;
    localparam int RCNT_W = bal_pkg::RCNT_W;
    localparam int LEN_W  = bal_pkg::LEN_W;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 80;
    localparam int BLOCK_ITEMS = 50;
    localparam int BLOCKS_PER_PHASE = 8;
    localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] data;
        logic [POS_W-1:0]  position;
        logic [RCNT_W-1:0] removed_count;
        logic [LEN_W-1:0]  length;
    } list_result_t;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [DATA_W-1:0] val;
        int                reps;
        bit                typed;
        list_result_t      result;
    } dir_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] value;
    logic                     rsp_valid;
    logic                     rsp_stall;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         position;
    logic [RCNT_W-1:0]        removed_count;
    logic [LEN_W-1:0]         length;

    // Shadow copy of the list, front at index 0.
    logic [DATA_W-1:0] shadow_list [DEPTH];
    int                shadow_len;

    list_result_t pending_results [$];
    bit           use_typed;
    list_result_t typed_result;
    int           error_count;
    int           cycle_count;
    int           send_idle;
    int           rcv_idle;
    int           hold_requests;
    int           hold_served;
    int           hold_left;
    logic [DATA_W-1:0] value_pool [8];

    dir_row_t dir_table [] = '{
        '{bal_pkg::REQ_POP_FRONT,  32'd0,        1, 1'b1,
          '{bal_pkg::ST_EMPTY, 32'd0, 4'd0, 5'd0, 5'd0}},
        '{bal_pkg::REQ_POP_BACK,   32'd0,        1, 1'b1,
          '{bal_pkg::ST_EMPTY, 32'd0, 4'd0, 5'd0, 5'd0}},
        '{bal_pkg::REQ_SEARCH,     32'd0,        1, 1'b1,
          '{bal_pkg::ST_NOTFOUND, 32'd0, 4'd0, 5'd0, 5'd0}},
        '{bal_pkg::REQ_REMOVE_ALL, 32'd5,        1, 1'b1,
          '{bal_pkg::ST_EMPTY, 32'd0, 4'd0, 5'd0, 5'd0}},
        '{bal_pkg::REQ_PUSH_BACK,  32'h7fffffff, 1, 1'b1,
          '{bal_pkg::ST_OK, 32'd0, 4'd0, 5'd0, 5'd1}},
        '{bal_pkg::REQ_PUSH_FRONT, 32'h80000000, 1, 1'b1,
          '{bal_pkg::ST_OK, 32'd0, 4'd0, 5'd0, 5'd2}},
        '{bal_pkg::REQ_PUSH_BACK,  32'hffffffff, 1, 1'b0, '{default: '0}},
        '{bal_pkg::REQ_SEARCH,     32'h7fffffff, 1, 1'b0, '{default: '0}},
        '{bal_pkg::REQ_SEARCH,     32'd123,      1, 1'b0, '{default: '0}},
        '{REQ_UNUSED_6,            32'd0,        1, 1'b0, '{default: '0}},
        '{REQ_UNUSED_7,            32'hffffffff, 1, 1'b0, '{default: '0}},
        '{bal_pkg::REQ_REMOVE_ALL, 32'hffffffff, 1, 1'b0, '{default: '0}},
        '{bal_pkg::REQ_REMOVE_ALL, 32'd42,       1, 1'b0, '{default: '0}},
        '{bal_pkg::REQ_POP_BACK,   32'd0,        1, 1'b0, '{default: '0}},
        '{bal_pkg::REQ_POP_FRONT,  32'd0,        1, 1'b0, '{default: '0}},
        '{bal_pkg::REQ_PUSH_FRONT, 32'h12345678, 15, 1'b0, '{default: '0}},
        '{bal_pkg::REQ_PUSH_BACK,  32'h0000ffff, 1, 1'b0, '{default: '0}},
        '{bal_pkg::REQ_PUSH_BACK,  32'd1,        1, 1'b1,
          '{bal_pkg::ST_FULL, 32'd0, 4'd0, 5'd0, 5'd16}},
        '{bal_pkg::REQ_PUSH_FRONT, 32'd1,        1, 1'b1,
          '{bal_pkg::ST_FULL, 32'd0, 4'd0, 5'd0, 5'd16}},
        '{bal_pkg::REQ_SEARCH,     32'h0000ffff, 1, 1'b0, '{default: '0}},
        '{bal_pkg::REQ_POP_BACK,   32'd0,        1, 1'b0, '{default: '0}},
        '{bal_pkg::REQ_PUSH_BACK,  32'h12345678, 1, 1'b0, '{default: '0}},
        '{bal_pkg::REQ_REMOVE_ALL, 32'h12345678, 1, 1'b1,
          '{bal_pkg::ST_OK, 32'h12345678, 4'd0, 5'd16, 5'd0}},
        '{bal_pkg::REQ_SEARCH,     32'h12345678, 1, 1'b1,
          '{bal_pkg::ST_NOTFOUND, 32'd0, 4'd0, 5'd0, 5'd0}}
    };

    bounded_array_list_engine_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_type      (req_type),
        .value         (value),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .data          (data),
        .position      (position),
        .removed_count (removed_count),
        .length        (length)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Applies one request to the shadow list and returns its result.
    function automatic list_result_t apply_list_request(logic [REQ_W-1:0] req,
                                                        logic [DATA_W-1:0] val);
        list_result_t r;
        int           kept;
        int           first;
        bit           any;
        r = '0;
        r.status = bal_pkg::ST_OK;
        case (req)
            bal_pkg::REQ_PUSH_BACK:
            begin
                if (shadow_len >= DEPTH)
                    r.status = bal_pkg::ST_FULL;
                else
                begin
                    shadow_list[shadow_len] = val;
                    r.position = shadow_len[POS_W-1:0];
                    shadow_len++;
                end
            end
            bal_pkg::REQ_PUSH_FRONT:
            begin
                if (shadow_len >= DEPTH)
                    r.status = bal_pkg::ST_FULL;
                else
                begin
                    for (int i = shadow_len; i > 0; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[0] = val;
                    shadow_len++;
                end
            end
            bal_pkg::REQ_POP_FRONT:
            begin
                if (shadow_len == 0)
                    r.status = bal_pkg::ST_EMPTY;
                else
                begin
                    r.data = shadow_list[0];
                    for (int i = 1; i < shadow_len; i++)
                        shadow_list[i-1] = shadow_list[i];
                    shadow_len--;
                end
            end
            bal_pkg::REQ_POP_BACK:
            begin
                if (shadow_len == 0)
                    r.status = bal_pkg::ST_EMPTY;
                else
                begin
                    shadow_len--;
                    r.data = shadow_list[shadow_len];
                    r.position = shadow_len[POS_W-1:0];
                end
            end
            bal_pkg::REQ_SEARCH:
            begin
                r.status = bal_pkg::ST_NOTFOUND;
                for (int i = shadow_len - 1; i >= 0; i--)
                begin
                    if (shadow_list[i] == val)
                    begin
                        r.status = bal_pkg::ST_OK;
                        r.data = val;
                        r.position = i[POS_W-1:0];
                    end
                end
            end
            bal_pkg::REQ_REMOVE_ALL:
            begin
                if (shadow_len == 0)
                    r.status = bal_pkg::ST_EMPTY;
                else
                begin
                    kept = 0;
                    first = 0;
                    any = 1'b0;
                    for (int i = 0; i < shadow_len; i++)
                    begin
                        if (shadow_list[i] == val)
                        begin
                            if (!any)
                                first = i;
                            any = 1'b1;
                        end
                        else
                        begin
                            shadow_list[kept] = shadow_list[i];
                            kept++;
                        end
                    end
                    if (any)
                    begin
                        r.data = val;
                        r.position = first[POS_W-1:0];
                        r.removed_count = 5'(shadow_len - kept);
                    end
                    else
                        r.status = bal_pkg::ST_NOTFOUND;
                    shadow_len = kept;
                end
            end
            default:
                r.status = bal_pkg::ST_OK;
        endcase
        r.length = shadow_len[LEN_W-1:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [DATA_W-1:0] exp_val,
                               logic [DATA_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name,
                     exp_val, act_val);
        end
    endtask

    // Offers one request, entered and left at a falling edge.
    task automatic offer_request(logic [REQ_W-1:0] req, logic [DATA_W-1:0] val,
                                 bit typed, list_result_t result);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid    <= 1'b1;
        req_type     <= req;
        value        <= val;
        use_typed    <= typed;
        typed_result <= result;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        rsp_stall = 1'b0;
        hold_served = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    always @(posedge clk)
    begin
        list_result_t predicted;
        list_result_t oldest;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                predicted = apply_list_request(req_type, value);
                pending_results.push_back(use_typed ? typed_result : predicted);
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result transaction with nothing expected, actual %h",
                             $time, {status, data, position, removed_count, length});
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    check_field("status", 32'(oldest.status), 32'(status));
                    check_field("data", oldest.data, data);
                    check_field("position", 32'(oldest.position), 32'(position));
                    check_field("removed_count", 32'(oldest.removed_count),
                                32'(removed_count));
                    check_field("length", 32'(oldest.length), 32'(length));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [REQ_W-1:0]  req;
        logic [DATA_W-1:0] val;
        int                pick;
        bit                filling;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_type = '0;
        value = '0;
        use_typed = 1'b0;
        typed_result = '0;
        error_count = 0;
        cycle_count = 0;
        hold_requests = 0;
        shadow_len = 0;
        foreach (shadow_list[i])
            shadow_list[i] = '0;
        send_idle = 26;
        rcv_idle = 63;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_table[i])
            repeat (dir_table[i].reps)
                offer_request(dir_table[i].req, dir_table[i].val, dir_table[i].typed,
                              dir_table[i].result);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 26 : (phase == 1) ? 63 : 0;
            rcv_idle  = (phase == 0) ? 63 : (phase == 1) ? 26 : 0;
            // With no random stalls the hold-off is what backs the block up.
            if (phase == 2)
                hold_requests++;
            for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++)
            begin
                filling = (blk % 2 == 0);
                foreach (value_pool[j])
                    value_pool[j] = ($urandom_range(9) == 0) ?
                                    (j[0] ? 32'h7fffffff : 32'h80000000) : $urandom;
                for (int k = 0; k < BLOCK_ITEMS; k++)
                begin
                    pick = $urandom_range(99);
                    if (filling)
                        req = (pick < 35) ? bal_pkg::REQ_PUSH_BACK :
                              (pick < 60) ? bal_pkg::REQ_PUSH_FRONT :
                              (pick < 70) ? bal_pkg::REQ_POP_FRONT :
                              (pick < 78) ? bal_pkg::REQ_POP_BACK :
                              (pick < 89) ? bal_pkg::REQ_SEARCH :
                              (pick < 97) ? bal_pkg::REQ_REMOVE_ALL :
                              (pick < 98) ? REQ_UNUSED_6 : REQ_UNUSED_7;
                    else
                        req = (pick < 15) ? bal_pkg::REQ_PUSH_BACK :
                              (pick < 25) ? bal_pkg::REQ_PUSH_FRONT :
                              (pick < 50) ? bal_pkg::REQ_POP_FRONT :
                              (pick < 73) ? bal_pkg::REQ_POP_BACK :
                              (pick < 86) ? bal_pkg::REQ_SEARCH :
                              (pick < 98) ? bal_pkg::REQ_REMOVE_ALL :
                              (pick < 99) ? REQ_UNUSED_6 : REQ_UNUSED_7;
                    val = ($urandom_range(4) == 0) ? $urandom :
                          value_pool[$urandom_range(7)];
                    offer_request(req, val, 1'b0, '0);
                end
            end
        end
        req_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/bal_pkg.sv
src/bal_cell.sv
src/bounded_array_list_engine_unit.sv
tb/bounded_array_list_engine_unit_tb.sv
